>>> hdl/noise_interval_statistics_unit_defines.svh
// Assertion macros used by the port-level checker of the noise interval statistics unit.
`ifndef NOISE_INTERVAL_STATISTICS_UNIT_DEFINES_SVH
`define NOISE_INTERVAL_STATISTICS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NIS_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NIS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

>>> hdl/nis_pkg.sv
// Widths, operation codes and item layouts of the noise interval statistics unit.
`default_nettype none

package nis_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 20;
	localparam int OP_BITS     = 3;
	localparam int LOC_BITS    = 16;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_RAW_BITS = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
	localparam int SQ_BITS     = (SQ_RAW_BITS > 64) ? 64 : SQ_RAW_BITS;

	// Operation codes carried in the tuser field of an input item; the spare codes change nothing.
	typedef enum logic [OP_BITS-1:0] {
		OP_ADD        = 3'd0,
		OP_CHECKPOINT = 3'd1,
		OP_RESTORE    = 3'd2,
		OP_END        = 3'd3,
		OP_START      = 3'd4,
		OP_SPARE5     = 3'd5,
		OP_SPARE6     = 3'd6,
		OP_SPARE7     = 3'd7
	} op_t;

	// Input item data layout; the op travels in tuser.
	localparam int I_VALUE   = 0;
	localparam int I_LOC     = I_VALUE + SAMPLE_BITS;
	localparam int IN_BITS   = I_LOC + LOC_BITS;
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;

	// Result item layout.
	localparam int O_LEFT    = 0;
	localparam int O_RIGHT   = O_LEFT + LOC_BITS;
	localparam int O_PEAK    = O_RIGHT + LOC_BITS;
	localparam int O_FLOOR   = O_PEAK + SAMPLE_BITS;
	localparam int O_SUM     = O_FLOOR + SAMPLE_BITS;
	localparam int O_SQ      = O_SUM + SUM_BITS;
	localparam int O_MAXC    = O_SQ + SQ_BITS;
	localparam int O_MINC    = O_MAXC + COUNT_BITS;
	localparam int O_CNT     = O_MINC + COUNT_BITS;
	localparam int O_TENT    = O_CNT + COUNT_BITS;
	localparam int O_END     = O_TENT + 1;
	localparam int OUT_BITS  = O_END + 1;
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> hdl/noise_interval_statistics_unit.sv
// Top level of the noise interval statistics unit: input register, statistic sets and result register.
//
// The unit takes one item per clock cycle unless the result side stalls, and returns one result
// item for each item, showing the committed statistics after that item. An accepted item waits in
// the input register, where the square of its sample, the statistic set update and the result are
// computed; when it moves on, the statistic sets and the result register are written together.
// The rate of one item per cycle is set by that single update step, which reads and writes the
// statistic sets in the same step. Back pressure on the result side holds both registers; the
// unit still accepts an item while a result waits as long as the input register is empty.
// Reset puts both statistic sets in their empty state.
`default_nettype none

module noise_interval_statistics_unit
	import nis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0 up: value, location.
	input  wire logic [IN_TDATA-1:0]  s_tdata,
	// Fields from bit 0 up: op.
	input  wire logic [OP_BITS-1:0]   s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// Fields from bit 0 up: left_edge, right_edge, peak_value, floor_value, sample_sum,
	// square_sum, maxima_count, minima_count, samples_count, tentative_active,
	// interval_ended, zero fill.
	output logic [OUT_TDATA-1:0]      m_tdata
);

	typedef struct packed {
		logic [LOC_BITS-1:0]    left;
		logic [SAMPLE_BITS-1:0] peak;
		logic [SAMPLE_BITS-1:0] floor_v;
		logic [SUM_BITS-1:0]    sum;
		logic [SQ_BITS-1:0]     sq;
		logic [COUNT_BITS-1:0]  maxc;
		logic [COUNT_BITS-1:0]  minc;
		logic [COUNT_BITS-1:0]  cnt;
	} stat_t;

	localparam logic [SAMPLE_BITS-1:0] PEAK_EMPTY  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] FLOOR_EMPTY = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam stat_t STAT_EMPTY = '{
		left: '0, peak: PEAK_EMPTY, floor_v: FLOOR_EMPTY, sum: '0, sq: '0,
		maxc: '0, minc: '0, cnt: '0
	};

	// Saturating count step.
	function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// Pipeline control.
	logic v_s1, out_valid_q;
	logic out_load, s1_open, s1_move, in_take;

	assign out_load = !out_valid_q || m_tready;
	assign s1_open  = !v_s1 || out_load;
	assign s1_move  = v_s1 && out_load;
	assign s_tready = s1_open;
	assign in_take  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_open) begin
				v_s1 <= s_tvalid;
			end
			if (out_load) begin
				out_valid_q <= v_s1;
			end
		end
	end

	// Input register.
	logic [OP_BITS-1:0]     op_s1;
	logic [SAMPLE_BITS-1:0] value_s1;
	logic [LOC_BITS-1:0]    loc_s1;

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= s_tuser;
			value_s1 <= s_tdata[I_VALUE +: SAMPLE_BITS];
			loc_s1   <= s_tdata[I_LOC +: LOC_BITS];
		end
	end

	// Square of the sample: never negative and fits 2*SAMPLE_BITS-1 bits.
	logic signed [2*SAMPLE_BITS-1:0] square;

	assign square = $signed(value_s1) * $signed(value_s1);

	// Statistic state.
	stat_t                  com_q, ten_q;
	logic [LOC_BITS-1:0]    right_q;
	logic [SAMPLE_BITS-1:0] last_q;
	logic                   rising_q, tent_q, ended_q;

	stat_t                  com_d, ten_d, sel, upd;
	logic [LOC_BITS-1:0]    right_d;
	logic [SAMPLE_BITS-1:0] last_d;
	logic                   rising_d, tent_d, ended_d;
	logic [SUM_BITS:0]      sum_w;
	logic [SQ_BITS:0]       sq_w;
	logic [OUT_TDATA-1:0]   out_word;

	// Sample added to the set that is currently active.
	always_comb begin
		sel = tent_q ? ten_q : com_q;
		upd = sel;
		rising_d = rising_q;
		upd.left = loc_s1;
		if ($signed(value_s1) > $signed(sel.peak)) begin
			upd.peak = value_s1;
		end
		if ($signed(value_s1) < $signed(sel.floor_v)) begin
			upd.floor_v = value_s1;
		end
		sum_w = {sel.sum[SUM_BITS-1], sel.sum}
			+ {{(SUM_BITS+1-SAMPLE_BITS){value_s1[SAMPLE_BITS-1]}}, value_s1};
		if (sum_w[SUM_BITS] != sum_w[SUM_BITS-1]) begin
			upd.sum = {sum_w[SUM_BITS], {(SUM_BITS-1){~sum_w[SUM_BITS]}}};
		end else begin
			upd.sum = sum_w[SUM_BITS-1:0];
		end
		sq_w = {1'b0, sel.sq} + (SQ_BITS+1)'(square[2*SAMPLE_BITS-2:0]);
		upd.sq = sq_w[SQ_BITS] ? {SQ_BITS{1'b1}} : sq_w[SQ_BITS-1:0];
		if (rising_q) begin
			if ($signed(value_s1) < $signed(last_q)) begin
				rising_d = 1'b0;
				upd.maxc = count_up(sel.maxc);
			end
		end else if ($signed(value_s1) > $signed(last_q)) begin
			rising_d = 1'b1;
			upd.minc = count_up(sel.minc);
		end
		upd.cnt = count_up(sel.cnt);
	end

	// Next state for each op.
	always_comb begin
		com_d   = com_q;
		ten_d   = ten_q;
		right_d = right_q;
		last_d  = last_q;
		tent_d  = tent_q;
		ended_d = ended_q;
		unique case (op_s1)
			OP_ADD: begin
				if (!ended_q) begin
					if (tent_q) begin
						ten_d = upd;
					end else begin
						com_d = upd;
					end
					last_d = value_s1;
				end
			end
			OP_CHECKPOINT: begin
				if (!tent_q && !ended_q) begin
					ten_d  = com_q;
					tent_d = 1'b1;
				end
			end
			OP_RESTORE: begin
				if (tent_q && !ended_q) begin
					com_d  = ten_q;
					tent_d = 1'b0;
				end
			end
			OP_END: begin
				ended_d = 1'b1;
			end
			OP_START: begin
				com_d      = STAT_EMPTY;
				com_d.left = loc_s1;
				ten_d      = STAT_EMPTY;
				ten_d.left = loc_s1;
				right_d    = loc_s1;
				last_d     = value_s1;
				tent_d     = 1'b0;
				ended_d    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// The rising flag changes only when a sample is really added or an interval starts.
	logic rising_n;
	always_comb begin
		rising_n = rising_q;
		if (op_s1 == OP_ADD && !ended_q) begin
			rising_n = rising_d;
		end else if (op_s1 == OP_START) begin
			rising_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			com_q    <= STAT_EMPTY;
			ten_q    <= STAT_EMPTY;
			right_q  <= '0;
			last_q   <= '0;
			rising_q <= 1'b0;
			tent_q   <= 1'b0;
			ended_q  <= 1'b0;
		end else if (s1_move) begin
			com_q    <= com_d;
			ten_q    <= ten_d;
			right_q  <= right_d;
			last_q   <= last_d;
			rising_q <= rising_n;
			tent_q   <= tent_d;
			ended_q  <= ended_d;
		end
	end

	// Result item from the committed set after the op.
	always_comb begin
		out_word = '0;
		out_word[O_LEFT  +: LOC_BITS]    = com_d.left;
		out_word[O_RIGHT +: LOC_BITS]    = right_d;
		out_word[O_PEAK  +: SAMPLE_BITS] = com_d.peak;
		out_word[O_FLOOR +: SAMPLE_BITS] = com_d.floor_v;
		out_word[O_SUM   +: SUM_BITS]    = com_d.sum;
		out_word[O_SQ    +: SQ_BITS]     = com_d.sq;
		out_word[O_MAXC  +: COUNT_BITS]  = com_d.maxc;
		out_word[O_MINC  +: COUNT_BITS]  = com_d.minc;
		out_word[O_CNT   +: COUNT_BITS]  = com_d.cnt;
		out_word[O_TENT]                 = tent_d;
		out_word[O_END]                  = ended_d;
	end

	logic [OUT_TDATA-1:0] out_data_q;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= out_word;
		end
	end

	assign m_tdata = out_data_q;

endmodule

`default_nettype wire

>>> hdl/nis_checker.sv
// Port-level checks of the noise interval statistics unit and their binding.
`default_nettype none
`include "noise_interval_statistics_unit_defines.svh"

module nis_checker
	import nis_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [OUT_TDATA-1:0] m_tdata
);

	logic [SAMPLE_BITS-1:0] peak, floor_v;
	logic [SUM_BITS-1:0]    sum;
	logic [SQ_BITS-1:0]     sq;
	logic [COUNT_BITS-1:0]  maxc, minc, cnt;
	logic                   set_empty, sums_clear;

	assign peak       = m_tdata[O_PEAK  +: SAMPLE_BITS];
	assign floor_v    = m_tdata[O_FLOOR +: SAMPLE_BITS];
	assign sum        = m_tdata[O_SUM   +: SUM_BITS];
	assign sq         = m_tdata[O_SQ    +: SQ_BITS];
	assign maxc       = m_tdata[O_MAXC  +: COUNT_BITS];
	assign minc       = m_tdata[O_MINC  +: COUNT_BITS];
	assign cnt        = m_tdata[O_CNT   +: COUNT_BITS];
	assign set_empty  = (cnt == '0);
	assign sums_clear = (sum == '0) && (sq == '0) && (maxc == '0) && (minc == '0);

	// A stalled result item holds still.
	`NIS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// The input side only stalls behind a result item that waits.
	`NIS_ASSERT_NOW(a_in_stall, clk, arst_n, !s_tready, m_tvalid && !m_tready)

	// A set that holds samples has its maximum at or above its minimum.
	`NIS_ASSERT_NOW(a_peak_floor, clk, arst_n, m_tvalid && !set_empty, $signed(peak) >= $signed(floor_v))

	// An empty set has no sums and no reversals.
	`NIS_ASSERT_NOW(a_empty_set, clk, arst_n, m_tvalid && set_empty, sums_clear)

	// Each reversal is counted together with a sample.
	`NIS_ASSERT_NOW(a_rev_count, clk, arst_n, m_tvalid, maxc <= cnt && minc <= cnt)

endmodule

bind noise_interval_statistics_unit nis_checker u_nis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the noise interval statistics unit.
`default_nettype none

module tb_top
	import nis_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// One statistic set: committed or tentative.
	typedef struct {
		logic [LOC_BITS-1:0]           left;
		logic signed [SAMPLE_BITS-1:0] peak;
		logic signed [SAMPLE_BITS-1:0] floor_v;
		logic signed [SUM_BITS-1:0]    sum;
		logic [SQ_BITS-1:0]            sq;
		logic [COUNT_BITS-1:0]         maxc;
		logic [COUNT_BITS-1:0]         minc;
		logic [COUNT_BITS-1:0]         cnt;
	} stat_set_t;

	// Fields of one result item.
	typedef struct {
		logic [LOC_BITS-1:0]           left;
		logic [LOC_BITS-1:0]           right;
		logic signed [SAMPLE_BITS-1:0] peak;
		logic signed [SAMPLE_BITS-1:0] floor_v;
		logic signed [SUM_BITS-1:0]    sum;
		logic [SQ_BITS-1:0]            sq;
		logic [COUNT_BITS-1:0]         maxc;
		logic [COUNT_BITS-1:0]         minc;
		logic [COUNT_BITS-1:0]         cnt;
		logic                          tent;
		logic                          ended;
	} stat_result_t;

	// One row of the directed stimulus; typed rows carry their own expected result.
	typedef struct {
		op_t                           op;
		logic signed [SAMPLE_BITS-1:0] value;
		logic [LOC_BITS-1:0]           loc;
		bit                            typed;
		stat_result_t                  want;
	} stim_row_t;

	localparam int DIRECTED_ROWS   = 25;
	localparam int RANDOM_ITEMS    = 1925;
	localparam int DRAIN_CYCLES    = 16;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int LONG_STALL      = 120;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_TDATA-1:0]  s_tdata = '0;
	logic [OP_BITS-1:0]   s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_TDATA-1:0] m_tdata;

	noise_interval_statistics_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: set 0 is committed, set 1 tentative.
	stat_set_t                     stats [2];
	logic [LOC_BITS-1:0]           right_edge;
	logic signed [SAMPLE_BITS-1:0] prev_sample;
	logic                          rising;
	logic                          tentative;
	logic                          ended;

	stat_result_t pending_results [$];
	logic signed [SAMPLE_BITS-1:0] last_drawn = '0;

	int sender_gap_max = 14;
	int receiver_wait_max = 14;
	int items_sent = 0;
	int items_effective = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int adds_taken = 0;
	int checkpoints_taken = 0;
	int restores_taken = 0;
	int starts_taken = 0;
	int ends_taken = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// Spare op right after reset shows the empty statistics.
		'{OP_SPARE5, 16'sh1234, 16'h5678, 1'b1, '{16'h0000, 16'h0000, 16'sh8000,
			16'sh7fff, 36'sd0, 51'd0, 20'd0, 20'd0, 20'd0, 1'b0, 1'b0}},
		'{OP_START, 16'sh0000, 16'hffff, 1'b1, '{16'hffff, 16'hffff, 16'sh8000,
			16'sh7fff, 36'sd0, 51'd0, 20'd0, 20'd0, 20'd0, 1'b0, 1'b0}},
		// Largest sample after a zero start counts a minimum.
		'{OP_ADD, 16'sh7fff, 16'd100, 1'b1, '{16'd100, 16'hffff, 16'sh7fff,
			16'sh7fff, 36'sd32767, 51'd1073676289, 20'd0, 20'd1, 20'd1, 1'b0, 1'b0}},
		'{OP_ADD, 16'sh8000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_ADD, 16'sh8000, 16'h0005, 1'b0, '{default: 0}},
		'{OP_ADD, 16'sh7fff, 16'hffff, 1'b0, '{default: 0}},
		'{OP_CHECKPOINT, 16'shffff, 16'hffff, 1'b0, '{default: 0}},
		'{OP_ADD, 16'sd1000, 16'h0003, 1'b0, '{default: 0}},
		'{OP_CHECKPOINT, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_ADD, -16'sd5, 16'h0002, 1'b0, '{default: 0}},
		'{OP_RESTORE, 16'sha5a5, 16'h5a5a, 1'b0, '{default: 0}},
		'{OP_RESTORE, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_CHECKPOINT, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_ADD, 16'sd7, 16'h0001, 1'b0, '{default: 0}},
		// Start while tentative drops everything.
		'{OP_START, 16'sh8000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'sh8000,
			16'sh7fff, 36'sd0, 51'd0, 20'd0, 20'd0, 20'd0, 1'b0, 1'b0}},
		'{OP_ADD, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_CHECKPOINT, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_END, 16'sh5555, 16'haaaa, 1'b0, '{default: 0}},
		'{OP_ADD, 16'sh7fff, 16'h0009, 1'b0, '{default: 0}},
		'{OP_CHECKPOINT, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_RESTORE, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_END, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_SPARE6, 16'shffff, 16'hffff, 1'b0, '{default: 0}},
		'{OP_SPARE7, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
		'{OP_START, 16'sh1234, 16'haaaa, 1'b0, '{default: 0}}
	};

	// Prints one line per mismatch and counts them all.
	task automatic flag_mismatch(input string what, input int idx, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH result %0d: %s got %h expected %h", idx, what, got, want);
		mismatch_count++;
	endtask

	function automatic stat_set_t empty_set();
		stat_set_t e;
		e.left = '0;
		e.peak = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		e.floor_v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		e.sum = '0;
		e.sq = '0;
		e.maxc = '0;
		e.minc = '0;
		e.cnt = '0;
		return e;
	endfunction

	function automatic logic [COUNT_BITS-1:0] count_sat(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// Applies one item to the predictor and returns the committed view after it.
	task automatic predict_statistics(input op_t op,
			input logic signed [SAMPLE_BITS-1:0] smp, input logic [LOC_BITS-1:0] loc,
			output stat_result_t res, output bit acted);
		int k;
		longint sum_next, sum_hi, sum_lo;
		longint unsigned sq_val, sq_lim;
		acted = 1'b0;
		k = tentative ? 1 : 0;
		case (op)
			OP_ADD: begin
				if (!ended) begin
					sum_hi = (longint'(1) <<< (SUM_BITS - 1)) - 1;
					sum_lo = -sum_hi - 1;
					sq_lim = (64'd1 << SQ_BITS) - 64'd1;
					sq_val = longint'(smp) * longint'(smp);
					sum_next = longint'(stats[k].sum) + longint'(smp);
					stats[k].left = loc;
					if (smp > stats[k].peak) stats[k].peak = smp;
					if (smp < stats[k].floor_v) stats[k].floor_v = smp;
					if (sum_next > sum_hi) stats[k].sum = sum_hi[SUM_BITS-1:0];
					else if (sum_next < sum_lo) stats[k].sum = sum_lo[SUM_BITS-1:0];
					else stats[k].sum = sum_next[SUM_BITS-1:0];
					if (64'(stats[k].sq) > sq_lim - sq_val || sq_val > sq_lim)
						stats[k].sq = sq_lim[SQ_BITS-1:0];
					else
						stats[k].sq = stats[k].sq + sq_val[SQ_BITS-1:0];
					// The direction state is shared by both sets; the active set counts the reversal.
					if (rising) begin
						if (smp < prev_sample) begin
							rising = 1'b0;
							stats[k].maxc = count_sat(stats[k].maxc);
						end
					end else if (smp > prev_sample) begin
						rising = 1'b1;
						stats[k].minc = count_sat(stats[k].minc);
					end
					stats[k].cnt = count_sat(stats[k].cnt);
					prev_sample = smp;
					acted = 1'b1;
					adds_taken++;
				end
			end
			OP_CHECKPOINT: begin
				if (!tentative && !ended) begin
					stats[1] = stats[0];
					tentative = 1'b1;
					acted = 1'b1;
					checkpoints_taken++;
				end
			end
			OP_RESTORE: begin
				if (tentative && !ended) begin
					stats[0] = stats[1];
					tentative = 1'b0;
					acted = 1'b1;
					restores_taken++;
				end
			end
			OP_END: begin
				acted = !ended;
				ended = 1'b1;
				ends_taken++;
			end
			OP_START: begin
				stats[0] = empty_set();
				stats[1] = empty_set();
				stats[0].left = loc;
				stats[1].left = loc;
				right_edge = loc;
				prev_sample = smp;
				rising = 1'b0;
				tentative = 1'b0;
				ended = 1'b0;
				acted = 1'b1;
				starts_taken++;
			end
			default: begin
			end
		endcase
		res.left = stats[0].left;
		res.right = right_edge;
		res.peak = stats[0].peak;
		res.floor_v = stats[0].floor_v;
		res.sum = stats[0].sum;
		res.sq = stats[0].sq;
		res.maxc = stats[0].maxc;
		res.minc = stats[0].minc;
		res.cnt = stats[0].cnt;
		res.tent = tentative;
		res.ended = ended;
	endtask

	// Offers one item, waits for it to be taken, records its expectation, then may idle for a random gap.
	task automatic send_item(input op_t op, input logic signed [SAMPLE_BITS-1:0] smp,
			input logic [LOC_BITS-1:0] loc, input bit typed, input stat_result_t typed_want);
		logic [IN_TDATA-1:0] word;
		stat_result_t predicted;
		bit acted;
		int gap;
		word = '0;
		word[I_VALUE +: SAMPLE_BITS] = smp;
		word[I_LOC +: LOC_BITS] = loc;
		s_tdata <= word;
		s_tuser <= op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_statistics(op, smp, loc, predicted, acted);
		pending_results.push_back(typed ? typed_want : predicted);
		items_sent++;
		if (acted) items_effective++;
		last_drawn = smp;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender stops offering until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Samples: extremes, small steps around the last one (plateaus and reversals), or anything.
	function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r) inside
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			[1:4]: return last_drawn + 16'($signed($urandom_range(0, 6)) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic op_t pick_body_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return OP_ADD;
		if (r < 88) return OP_CHECKPOINT;
		if (r < 95) return OP_RESTORE;
		if (r < 97) return op_t'($urandom_range(OP_SPARE5, OP_SPARE7));
		return op_t'($urandom_range(OP_ADD, OP_SPARE7));
	endfunction

	// Main stimulus: reset, directed table, then random intervals.
	initial begin : stimulus
		int len;
		bit mid_pause_done;
		int guard;
		stats[0] = empty_set();
		stats[1] = empty_set();
		right_edge = '0;
		prev_sample = '0;
		rising = 1'b0;
		tentative = 1'b0;
		ended = 1'b0;
		mid_pause_done = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].loc,
				directed_rows[i].typed, directed_rows[i].want);
		end
		drain_results();

		// Random intervals: mostly well-formed, with broken and noisy stretches.
		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
			if (!mid_pause_done && items_sent > 1000) begin
				drain_results();
				mid_pause_done = 1'b1;
			end
			send_item(OP_START, draw_sample(), 16'($urandom), 1'b0, '{default: 0});
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
			repeat (len) begin
				send_item(pick_body_op(), draw_sample(), 16'($urandom), 1'b0, '{default: 0});
			end
			if ($urandom_range(0, 3) != 0)
				send_item(OP_END, draw_sample(), 16'($urandom), 1'b0, '{default: 0});
			repeat ($urandom_range(0, 3)) begin
				send_item(op_t'($urandom_range(OP_ADD, OP_SPARE7)), draw_sample(),
					16'($urandom), 1'b0, '{default: 0});
			end
		end
		s_tvalid <= 1'b0;

		// Wait for outstanding results, then watch for strays.
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never delivered", results_checked,
				64'(pending_results.size()), 64'd0);

		$display("Covered %0d items (%0d directed, %0d with effect), %0d results checked.",
			items_sent, DIRECTED_ROWS, items_effective, results_checked);
		$display("Samples %0d, checkpoints %0d, restores %0d, starts %0d, ends %0d.",
			adds_taken, checkpoints_taken, restores_taken, starts_taken, ends_taken);
		if (mismatch_count == 0) begin
			$display("noise_interval_statistics_unit verification clean");
		end else begin
			$display("noise_interval_statistics_unit verification failed");
		end
		$finish;
	end

	// Result side: random stalls, idle-free stretches and two long hold-offs.
	initial begin : result_sink
		int wait_cycles;
		int taken;
		taken = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 64 == 0)
				receiver_wait_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
			wait_cycles = (taken == 40 || taken == 1200) ? LONG_STALL
				: $urandom_range(0, receiver_wait_max);
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// Compares every accepted result item with the oldest expectation.
	always @(posedge clk) begin : result_check
		stat_result_t got;
		stat_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.left = m_tdata[O_LEFT +: LOC_BITS];
			got.right = m_tdata[O_RIGHT +: LOC_BITS];
			got.peak = m_tdata[O_PEAK +: SAMPLE_BITS];
			got.floor_v = m_tdata[O_FLOOR +: SAMPLE_BITS];
			got.sum = m_tdata[O_SUM +: SUM_BITS];
			got.sq = m_tdata[O_SQ +: SQ_BITS];
			got.maxc = m_tdata[O_MAXC +: COUNT_BITS];
			got.minc = m_tdata[O_MINC +: COUNT_BITS];
			got.cnt = m_tdata[O_CNT +: COUNT_BITS];
			got.tent = m_tdata[O_TENT];
			got.ended = m_tdata[O_END];
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no expectation", results_checked, 64'd0, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.left !== want.left)
					flag_mismatch("left_edge", results_checked, 64'(got.left), 64'(want.left));
				if (got.right !== want.right)
					flag_mismatch("right_edge", results_checked, 64'(got.right), 64'(want.right));
				if (got.peak !== want.peak)
					flag_mismatch("peak_value", results_checked, 64'(got.peak), 64'(want.peak));
				if (got.floor_v !== want.floor_v)
					flag_mismatch("floor_value", results_checked, 64'(got.floor_v),
						64'(want.floor_v));
				if (got.sum !== want.sum)
					flag_mismatch("sample_sum", results_checked, 64'(got.sum), 64'(want.sum));
				if (got.sq !== want.sq)
					flag_mismatch("square_sum", results_checked, 64'(got.sq), 64'(want.sq));
				if (got.maxc !== want.maxc)
					flag_mismatch("maxima_count", results_checked, 64'(got.maxc), 64'(want.maxc));
				if (got.minc !== want.minc)
					flag_mismatch("minima_count", results_checked, 64'(got.minc), 64'(want.minc));
				if (got.cnt !== want.cnt)
					flag_mismatch("samples_count", results_checked, 64'(got.cnt), 64'(want.cnt));
				if (got.tent !== want.tent)
					flag_mismatch("tentative_active", results_checked, 64'(got.tent),
						64'(want.tent));
				if (got.ended !== want.ended)
					flag_mismatch("interval_ended", results_checked, 64'(got.ended),
						64'(want.ended));
			end
			results_checked++;
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#2000000;
		$display("noise_interval_statistics_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
